### rtl/core/base64_to_word_unpacker_macros.svh
// Assertion macros used by the checker file.
`ifndef BASE64_TO_WORD_UNPACKER_MACROS_SVH
`define BASE64_TO_WORD_UNPACKER_MACROS_SVH

// Checked only while out of reset.
`define B64U_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every edge, reset included.
`define B64U_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/b64u_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_pkg
// Types, constants and the character decode shared by the unpacker modules.
// ----------------------------------------------------------------------------
package b64u_pkg;

  localparam int unsigned CharW   = 8;
  localparam int unsigned SextetW = 6;
  localparam int unsigned WordW   = 64;
  localparam int unsigned HalfW   = 32;
  localparam int unsigned CountW  = 7;
  localparam int unsigned RestW   = 3;

  // Configuration register indexes
  localparam logic CFG_WORD_IS_64 = 1'b0;
  localparam logic CFG_SWAP_BYTES = 1'b1;

  // One decoded item between front and back
  typedef struct packed {
    logic [SextetW-1:0] sextet;
    logic               restart;
  } item_t;

  // Configuration as seen by the back end
  typedef struct packed {
    logic word_is_64;
    logic swap_bytes;
    logic clear;
  } cfg_t;

  // Standard alphabet; '=' and anything foreign give zero.
  function automatic logic [SextetW-1:0] decode_char(input logic [CharW-1:0] c);
    logic [SextetW-1:0] v;
    v = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = SextetW'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = SextetW'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = SextetW'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 6'd62;
    end else if (c == 8'h2F) begin
      v = 6'd63;
    end
    return v;
  endfunction

endpackage

### rtl/core/b64u_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_front
// Accepts characters and maps them to sextets for the item queue.
// ----------------------------------------------------------------------------
module b64u_front (
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [b64u_pkg::CharW-1:0]  char_i,
  input  logic                        restart_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output b64u_pkg::item_t             item_o
);

  assign s_axis_tready  = ~q_full_i;
  assign push_o         = s_axis_tvalid & ~q_full_i;
  assign item_o.sextet  = b64u_pkg::decode_char(char_i);
  assign item_o.restart = restart_i;

endmodule

### rtl/core/b64u_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_queue
// Two-entry item queue between the front and the back end.
// ----------------------------------------------------------------------------
module b64u_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  b64u_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output b64u_pkg::item_t item_o
);

  b64u_pkg::item_t entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = entry_q[rd_ptr_q];
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

### rtl/core/b64u_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_back
// Gathers sextets MSB-first into words and holds finished words for output.
// ----------------------------------------------------------------------------
module b64u_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  b64u_pkg::cfg_t              cfg_i,
  input  logic                        q_valid_i,
  input  b64u_pkg::item_t             q_item_i,
  output logic                        pop_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [b64u_pkg::WordW-1:0]  word_o
);

  localparam int unsigned WordW  = b64u_pkg::WordW;
  localparam int unsigned HalfW  = b64u_pkg::HalfW;
  localparam int unsigned CountW = b64u_pkg::CountW;
  localparam int unsigned RestW  = b64u_pkg::RestW;
  localparam int unsigned SxW    = b64u_pkg::SextetW;

  logic [WordW-1:0]  gath_q, gath_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [WordW-1:0]  out_data_q, out_data_d;

  logic [WordW-1:0]  g;
  logic [CountW-1:0] c, width, need;
  logic [RestW-1:0]  rest;
  logic              emit;
  logic [WordW-1:0]  word, swapped;

  assign pop_o = q_valid_i & (~out_valid_q | m_axis_tready);

  always_comb begin
    g     = q_item_i.restart ? '0 : gath_q;
    c     = q_item_i.restart ? '0 : cnt_q;
    width = cfg_i.word_is_64 ? CountW'(WordW) : CountW'(HalfW);
    need  = width - c;
    emit  = (need <= CountW'(SxW));
    rest  = RestW'(CountW'(SxW) - need);
    word  = (g << need) | WordW'(q_item_i.sextet >> rest);
    if (!cfg_i.word_is_64) begin
      word[WordW-1:HalfW] = '0;
    end
    swapped = '0;
    if (cfg_i.word_is_64) begin
      for (int i = 0; i < 8; i++) begin
        swapped[8*i +: 8] = word[8*(7-i) +: 8];
      end
    end else begin
      for (int i = 0; i < 4; i++) begin
        swapped[8*i +: 8] = word[8*(3-i) +: 8];
      end
    end

    gath_d = gath_q;
    cnt_d  = cnt_q;
    if (cfg_i.clear) begin
      gath_d = '0;
      cnt_d  = '0;
    end else if (pop_o) begin
      if (emit) begin
        // leftover low bits of this sextet open the next word
        gath_d = WordW'(q_item_i.sextet & SxW'((7'd1 << rest) - 7'd1));
        cnt_d  = CountW'(rest);
      end else begin
        gath_d = (g << SxW) | WordW'(q_item_i.sextet);
        cnt_d  = c + CountW'(SxW);
      end
    end

    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (pop_o && emit) begin
      out_valid_d = 1'b1;
      out_data_d  = cfg_i.swap_bytes ? swapped : word;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gath_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      gath_q      <= gath_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign word_o        = out_data_q;

endmodule

### rtl/core/base64_to_word_unpacker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_to_word_unpacker
// Base64 character stream to 32-bit or 64-bit raw words.
// ----------------------------------------------------------------------------
// Takes one base64 character per cycle unless the queue is full and emits a
// decoded word each time 32 or 64 bits have gathered (MSB-first, optional
// byte swap). A character passes the decode front end into a two-entry queue
// and is folded into the accumulator when the back end pops it, which it
// does unless a finished word is stalled in the output register; a word that
// the fold completes is registered in the output register. The back end
// takes one item per cycle while the output register is not stalled; while a
// word waits there the queue takes up to two more characters before the input
// stalls. Configuration is to be written by the user only while idle; the
// block does not enforce this. Writing word_is_64 restarts word alignment.
module base64_to_word_unpacker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tuser,   // [0] restart
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] word_out
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic        cfg_data_i
);

  logic            word_is_64_q, word_is_64_d;
  logic            swap_bytes_q, swap_bytes_d;
  b64u_pkg::cfg_t  cfg;
  logic            q_full, q_push, q_pop, q_valid;
  b64u_pkg::item_t f_item, q_item;

  always_comb begin
    word_is_64_d = word_is_64_q;
    swap_bytes_d = swap_bytes_q;
    cfg.clear    = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        b64u_pkg::CFG_WORD_IS_64: begin
          word_is_64_d = cfg_data_i;
          cfg.clear    = 1'b1;
        end
        b64u_pkg::CFG_SWAP_BYTES: begin
          swap_bytes_d = cfg_data_i;
        end
        default: begin
        end
      endcase
    end
    cfg.word_is_64 = word_is_64_q;
    cfg.swap_bytes = swap_bytes_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_is_64_q <= 1'b0;
      swap_bytes_q <= 1'b0;
    end else begin
      word_is_64_q <= word_is_64_d;
      swap_bytes_q <= swap_bytes_d;
    end
  end

  b64u_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .char_i        (s_axis_tdata),
    .restart_i     (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (q_push),
    .item_o        (f_item)
  );

  b64u_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  b64u_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_valid_i     (q_valid),
    .q_item_i      (q_item),
    .pop_o         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .word_o        (m_axis_tdata)
  );

endmodule

### rtl/core/b64u_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64u_checker
// Port-level checks on the unpacker, bound to the top level.
// ----------------------------------------------------------------------------
`include "base64_to_word_unpacker_macros.svh"

module b64u_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        cfg_we_i,
  input logic        cfg_idx_i,
  input logic        cfg_data_i
);

  logic w64_q;

  // mirror of the word size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w64_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == b64u_pkg::CFG_WORD_IS_64) begin
        w64_q <= cfg_data_i;
      end
    end
  end

  `B64U_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped while stalled")
  `B64U_ASSERT(a_out_stable, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata), "stalled result changed")
  `B64U_ASSERT(a_upper_zero, m_axis_tvalid && !w64_q |-> m_axis_tdata[63:32] == 32'h0, "upper half set in 32-bit mode")
  `B64U_ASSERT_ALWAYS(a_reset_empty, $rose(rst_ni) |-> !m_axis_tvalid, "result present out of reset")

endmodule

bind base64_to_word_unpacker b64u_checker u_b64u_checker (.*);

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the base64 to word unpacker.
// ----------------------------------------------------------------------------
// Feeds character items over the input stream and predicts every finished
// word with an independent software decoder. Both word sizes and byte orders
// are covered, together with restarts, padding and foreign codes, and changes
// of setting between phases. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam string ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] char_in
  logic        s_axis_tuser;   // [0] restart
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [63:0] word_out
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic        cfg_data_i;

  base64_to_word_unpacker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Decoder state
  logic [5:0]  sextet_lut [256];
  logic        wide_words;
  logic        swap_order;
  logic [63:0] acc_bits;
  int unsigned acc_count;
  logic [63:0] words_due [$];

  int unsigned chars_sent;
  int unsigned words_seen;
  int unsigned fail_count;
  bit          src_idle_on;
  bit          sink_idle_on;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("Verification failed");
    $finish;
  end

  function automatic logic [63:0] byte_swap(input logic [63:0] w, input int unsigned nbytes);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < nbytes; i++) begin
      r[8*(nbytes-1-i) +: 8] = w[8*i +: 8];
    end
    return r;
  endfunction

  // Fold one accepted character into the predicted accumulator
  task automatic fold_char(input logic [7:0] c, input logic restart);
    logic [5:0]  v;
    logic [63:0] word;
    int unsigned width;
    int unsigned need;
    int unsigned rest;
    v     = sextet_lut[c];
    width = wide_words ? 64 : 32;
    if (restart) begin
      acc_bits  = '0;
      acc_count = 0;
    end
    need = width - acc_count;
    if (need > 6) begin
      acc_bits  = (acc_bits << 6) | 64'(v);
      acc_count += 6;
    end else begin
      rest = 6 - need;
      word = (acc_bits << need) | 64'(v >> rest);
      if (!wide_words) word[63:32] = '0;
      // leftover low bits open the next word
      acc_bits  = 64'(v) & ((64'd1 << rest) - 64'd1);
      acc_count = rest;
      if (swap_order) word = byte_swap(word, width / 8);
      words_due.push_back(word);
    end
  endtask

  // Called at a falling edge; returns at a falling edge with tvalid still high
  task automatic send_char(input logic [7:0] c, input logic restart);
    if (src_idle_on) begin
      while ($urandom_range(0, 99) < 6) begin
        s_axis_tvalid <= 1'b0;
        @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tuser  <= restart;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    fold_char(c, restart);
    chars_sent++;
    @(negedge clk_i);
  endtask

  // Wait for every predicted word, then for anything still in the pipe
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (words_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == b64u_pkg::CFG_WORD_IS_64) begin
      wide_words = value;
      acc_bits   = '0;
      acc_count  = 0;
    end else begin
      swap_order = value;
    end
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 82) return ALPHABET[$urandom_range(0, 63)];
    if (roll < 88) return "=";
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic test_directed();
    logic [7:0] chars [24];
    chars = '{"A", "/", "Z", "a", "z", "0", "9", "+",
              "=", 8'h00, 8'hFF, 8'h80, 8'h40, 8'h5B, 8'h60, 8'h7B,
              8'h2F, 8'h2B, 8'h3A, 8'h2F, "/", "/", "/", "/"};
    write_reg(b64u_pkg::CFG_WORD_IS_64, 1'b0);
    write_reg(b64u_pkg::CFG_SWAP_BYTES, 1'b0);
    for (int i = 0; i < 24; i++) begin
      // restart in the middle of a word, and on the last all-ones stretch
      send_char(chars[i], (i == 7) || (i == 20));
    end
    settle();
  endtask

  task automatic test_stream(input int unsigned count, input logic wide, input logic swap,
                             input int unsigned restart_pct);
    write_reg(b64u_pkg::CFG_WORD_IS_64, wide);
    write_reg(b64u_pkg::CFG_SWAP_BYTES, swap);
    for (int i = 0; i < count; i++) begin
      send_char(pick_char(), $urandom_range(0, 99) < restart_pct);
    end
    settle();
  endtask

  // Sender drains the block now and then and flips the byte order mid-word
  task automatic test_swap_midword(input int unsigned count);
    write_reg(b64u_pkg::CFG_WORD_IS_64, 1'b1);
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 49) begin
        settle();
        write_reg(b64u_pkg::CFG_SWAP_BYTES, ~swap_order);
      end
      send_char(pick_char(), $urandom_range(0, 99) < 2);
    end
    settle();
  endtask

  // Output side: random back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= !(sink_idle_on && $urandom_range(0, 99) < 6);
  end

  always @(posedge clk_i) begin : check_words
    logic [63:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      words_seen++;
      if (words_due.size() == 0) begin
        $error("word_out: unexpected item %h", m_axis_tdata);
        fail_count++;
      end else begin
        want = words_due.pop_front();
        if (m_axis_tdata !== want) begin
          $error("word_out mismatch: expected %h, actual %h", want, m_axis_tdata);
          fail_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < 256; i++) sextet_lut[i] = '0;
    for (int i = 0; i < 64; i++) sextet_lut[ALPHABET[i]] = 6'(i);
    wide_words    = 1'b0;
    swap_order    = 1'b0;
    acc_bits      = '0;
    acc_count     = 0;
    chars_sent    = 0;
    words_seen    = 0;
    fail_count    = 0;
    src_idle_on   = 1'b1;
    sink_idle_on  = 1'b1;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = 1'b0;
    cfg_data_i    = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_stream(400, 1'b0, 1'b0, 2);
    test_stream(400, 1'b1, 1'b0, 2);
    test_stream(350, 1'b0, 1'b1, 2);
    // long stretch with no stalls on either side
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    test_stream(400, 1'b1, 1'b1, 2);
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    test_stream(200, 1'b0, 1'b0, 25);
    test_swap_midword(200);

    settle();
    if (words_due.size() != 0) begin
      $error("word_out: %0d expected items never arrived", words_due.size());
      fail_count++;
    end
    $display("Run covered %0d characters and %0d words: both word sizes, both byte orders,",
             chars_sent, words_seen);
    $display("restarts, padding and foreign codes, mid-word setting changes and stalls.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/b64u_pkg.sv
rtl/core/b64u_front.sv
rtl/core/b64u_queue.sv
rtl/core/b64u_back.sv
rtl/core/base64_to_word_unpacker.sv
rtl/core/b64u_checker.sv
sim/tb_top.sv
